@@ hw/rtl/brush_stroke_stamp_spacer_unit_defines.svh @@
// assertion macros for the brush stroke stamp spacer
// expects clk_i and rst_ni in the scope of use
`ifndef BRUSH_STROKE_STAMP_SPACER_UNIT_DEFINES_SVH
`define BRUSH_STROKE_STAMP_SPACER_UNIT_DEFINES_SVH

// same-cycle implication
`define BSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bss_pkg.sv @@
// shared constants for the brush stroke stamp spacer
// no dependencies
package bss_pkg;
  localparam int MAX_STAMPS  = 64;
  localparam int CANVAS_SIZE = 2048;

  localparam int COORD_W  = 11;
  localparam int SPACE_W  = 10;
  localparam int TRAV_W   = 20;
  localparam int STEPS_W  = 7;
  localparam int SQ_W     = 32;
  localparam int ROOT_W   = 16;
  localparam int DIV_NW   = 21;
  localparam int DIV_DW   = 16;

  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(CANVAS_SIZE - 1);
  localparam logic [TRAV_W-1:0]  TRAV_MAX  = '1;
  localparam logic [SPACE_W-1:0] SPACE_RST = SPACE_W'(32);
endpackage

@@ hw/rtl/bss_isqrt.sv @@
// digit-serial integer square root, two operand bits per cycle
// depends on bss_pkg
module bss_isqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bss_pkg::SQ_W-1:0]       op_i,
  output logic                           done_o,
  output logic [bss_pkg::ROOT_W-1:0]     root_o
);
  logic [bss_pkg::SQ_W-1:0]   op_q, op_d;
  logic [bss_pkg::ROOT_W:0]   rem_q, rem_d;
  logic [bss_pkg::ROOT_W-1:0] root_q, root_d;
  logic [3:0]                 cnt_q, cnt_d;
  logic                       busy_q, busy_d, done_q, done_d;
  logic [bss_pkg::ROOT_W+2:0] rem_w;
  logic [bss_pkg::ROOT_W+1:0] trial_w;

  always_comb begin
    op_d    = op_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    rem_w   = {rem_q, op_q[bss_pkg::SQ_W-1 -: 2]};
    trial_w = {root_q, 2'b01};
    if (start_i) begin
      op_d   = op_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      op_d = {op_q[bss_pkg::SQ_W-3:0], 2'b00};
      if (rem_w >= {1'b0, trial_w}) begin
        rem_d  = (bss_pkg::ROOT_W+1)'(rem_w - {1'b0, trial_w});
        root_d = {root_q[bss_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_w[bss_pkg::ROOT_W:0];
        root_d = {root_q[bss_pkg::ROOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

@@ hw/rtl/bss_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
// depends on bss_pkg
module bss_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bss_pkg::DIV_NW-1:0]   num_i,
  input  logic [bss_pkg::DIV_DW-1:0]   den_i,
  output logic                         done_o,
  output logic [bss_pkg::DIV_NW-1:0]   quo_o,
  output logic [bss_pkg::DIV_DW-1:0]   rem_o
);
  logic [bss_pkg::DIV_NW-1:0] num_q, num_d;
  logic [bss_pkg::DIV_DW-1:0] den_q, den_d, rem_q, rem_d;
  logic [4:0]                 cnt_q, cnt_d;
  logic                       busy_q, busy_d, done_q, done_d;
  logic [bss_pkg::DIV_DW:0]   rem_w;

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_w  = {rem_q, num_q[bss_pkg::DIV_NW-1]};
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_w >= {1'b0, den_q}) begin
        rem_d = bss_pkg::DIV_DW'(rem_w - {1'b0, den_q});
        num_d = {num_q[bss_pkg::DIV_NW-2:0], 1'b1};
      end else begin
        rem_d = rem_w[bss_pkg::DIV_DW-1:0];
        num_d = {num_q[bss_pkg::DIV_NW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(bss_pkg::DIV_NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = num_q;
  assign rem_o  = rem_q;
endmodule

@@ hw/rtl/brush_stroke_stamp_spacer_unit.sv @@
// brush stroke stamp spacer, top level: control sequencer and state
// depends on bss_pkg, bss_isqrt, bss_div and the defines header
//
// usage
//   input channel (in_valid_i / in_stall_o) takes one pen event per beat:
//   mode_i 0 starts a stroke, 1 reports a pen move to pen_x_i / pen_y_i
//   output channel (out_valid_o / out_stall_i) gives dab positions, one per
//   beat, with last_dab_o on the final dab caused by an event
//   cfg_we_i writes cfg_wdata_i into the dab spacing (1/16 pixel)
// timing
//   one event at a time; in_stall_o stays high until its last dab is in the
//   output register
//   start event: the sequencer goes to its start state, which loads the
//   dab into the output register once the slot is free and goes back to
//   idle in the same cycle, ready for the next event
//   move event: two square roots, one division for the dab count and two
//   for the per-axis step, then the dabs one by one; a pen on the anchor
//   skips the two per-axis divisions
//   a move emitting no dab finishes after the first root
// reset: spacing back to 32, anchor, pen and travelled length to zero
// a stalled output beat holds; the sequencer waits on it before the next dab
`include "brush_stroke_stamp_spacer_unit_defines.svh"
module brush_stroke_stamp_spacer_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bss_pkg::SPACE_W-1:0]     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic [bss_pkg::COORD_W-1:0]     pen_x_i,
  input  logic [bss_pkg::COORD_W-1:0]     pen_y_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bss_pkg::COORD_W-1:0]     dab_x_o,
  output logic [bss_pkg::COORD_W-1:0]     dab_y_o,
  output logic                            last_dab_o
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_START  = 4'd1;
  localparam logic [3:0] S_SQ     = 4'd2;
  localparam logic [3:0] S_ROOT   = 4'd3;
  localparam logic [3:0] S_ROOT_W = 4'd4;
  localparam logic [3:0] S_STEPS  = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_DIVX   = 4'd7;
  localparam logic [3:0] S_DIVX_W = 4'd8;
  localparam logic [3:0] S_DIVY   = 4'd9;
  localparam logic [3:0] S_DIVY_W = 4'd10;
  localparam logic [3:0] S_STEP   = 4'd11;
  localparam logic [3:0] S_EMIT   = 4'd12;

  localparam int CW = bss_pkg::COORD_W;

  logic [3:0] state_q, state_d;

  // architectural state
  logic [bss_pkg::SPACE_W-1:0] spacing_q;
  logic [CW-1:0] anchor_x_q, anchor_y_q, prev_x_q, prev_y_q;
  logic [bss_pkg::TRAV_W-1:0] trav_q;

  // per-event working registers
  logic [CW-1:0] px_q, py_q;
  logic          phase_q;
  logic [21:0]   sqx_q, sqy_q;
  logic [22:0]   sq_sum;
  logic [bss_pkg::ROOT_W-1:0] len_q;
  logic [bss_pkg::STEPS_W-1:0] steps_q, k_q;
  logic signed [22:0] ax_q, ay_q;
  logic [16:0] used_q;
  logic signed [15:0] qx_step_q, qy_step_q, qx_q, qy_q;
  logic [15:0] rx_step_q, ry_step_q, rx_q, ry_q;

  // output register
  logic          out_vld_q;
  logic [CW-1:0] dab_x_q, dab_y_q;
  logic          last_q;

  // serial units
  logic                           sq_start;
  logic                           sq_done;
  logic [bss_pkg::ROOT_W-1:0]     sq_root;
  logic                           div_start;
  logic [bss_pkg::DIV_NW-1:0]     div_num;
  logic [bss_pkg::DIV_DW-1:0]     div_den;
  logic                           div_done;
  logic [bss_pkg::DIV_NW-1:0]     div_quo;
  logic [bss_pkg::DIV_DW-1:0]     div_rem;

  // squared length can reach 23 bits
  assign sq_sum = {1'b0, sqx_q} + {1'b0, sqy_q};

  bss_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .op_i    ({1'b0, sq_sum, 8'h00}),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  bss_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // helpers
  logic [bss_pkg::SPACE_W-1:0] sp_w;
  logic [CW-1:0] pen_x_w, pen_y_w, opb_x, opb_y;
  logic signed [11:0] dx_w, dy_w;
  logic signed [23:0] sqx_full, sqy_full;
  logic [bss_pkg::TRAV_W:0] trav_sum;
  logic [bss_pkg::TRAV_W-1:0] trav_new;
  logic signed [22:0] ax_full, ay_full;
  logic [22:0] ax_mag, ay_mag;
  logic        sel_neg;
  logic signed [15:0] q_step_w;
  logic [15:0] r_step_w;
  logic [16:0] rx_sum, ry_sum;
  logic signed [16:0] pos_x, pos_y;
  logic [CW-1:0] dab_x_w, dab_y_w;
  logic          slot_free, out_load, last_w;
  logic [CW-1:0] load_x, load_y;

  assign sp_w    = (spacing_q == '0) ? bss_pkg::SPACE_W'(1) : spacing_q;
  assign pen_x_w = (pen_x_i > bss_pkg::COORD_MAX) ? bss_pkg::COORD_MAX : pen_x_i;
  assign pen_y_w = (pen_y_i > bss_pkg::COORD_MAX) ? bss_pkg::COORD_MAX : pen_y_i;

  // distance from prev or from anchor, depending on phase
  assign opb_x    = phase_q ? anchor_x_q : prev_x_q;
  assign opb_y    = phase_q ? anchor_y_q : prev_y_q;
  assign dx_w     = $signed({1'b0, px_q}) - $signed({1'b0, opb_x});
  assign dy_w     = $signed({1'b0, py_q}) - $signed({1'b0, opb_y});
  assign sqx_full = dx_w * dx_w;
  assign sqy_full = dy_w * dy_w;

  assign trav_sum = {1'b0, trav_q} + {5'b0, sq_root};
  assign trav_new = trav_sum[bss_pkg::TRAV_W] ? bss_pkg::TRAV_MAX
                                              : trav_sum[bss_pkg::TRAV_W-1:0];

  assign ax_full = $signed({1'b0, sp_w}) * dx_w;
  assign ay_full = $signed({1'b0, sp_w}) * dy_w;
  assign ax_mag  = ax_q[22] ? 23'(-ax_q) : ax_q;
  assign ay_mag  = ay_q[22] ? 23'(-ay_q) : ay_q;

  // floor division step from the magnitude quotient
  assign sel_neg = (state_q == S_DIVX_W) ? ax_q[22] : ay_q[22];
  always_comb begin
    if (!sel_neg) begin
      q_step_w = $signed(div_quo[15:0]);
      r_step_w = div_rem;
    end else if (div_rem != '0) begin
      q_step_w = -$signed(div_quo[15:0]) - 16'sd1;
      r_step_w = len_q - div_rem;
    end else begin
      q_step_w = -$signed(div_quo[15:0]);
      r_step_w = '0;
    end
  end

  assign rx_sum = {1'b0, rx_q} + {1'b0, rx_step_q};
  assign ry_sum = {1'b0, ry_q} + {1'b0, ry_step_q};

  // dab position, clamped to the canvas
  assign pos_x = $signed({6'b0, anchor_x_q}) + $signed({qx_q[15], qx_q});
  assign pos_y = $signed({6'b0, anchor_y_q}) + $signed({qy_q[15], qy_q});
  assign dab_x_w = pos_x[16] ? '0 : (pos_x > $signed({6'b0, bss_pkg::COORD_MAX}))
                   ? bss_pkg::COORD_MAX : pos_x[CW-1:0];
  assign dab_y_w = pos_y[16] ? '0 : (pos_y > $signed({6'b0, bss_pkg::COORD_MAX}))
                   ? bss_pkg::COORD_MAX : pos_y[CW-1:0];

  assign slot_free = !out_vld_q || !out_stall_i;
  assign last_w    = (state_q == S_START) || (k_q == steps_q);
  assign out_load  = slot_free && ((state_q == S_START) || (state_q == S_EMIT));
  assign load_x    = (state_q == S_START) ? px_q : dab_x_w;
  assign load_y    = (state_q == S_START) ? py_q : dab_y_w;

  // sequencer
  always_comb begin
    state_d   = state_q;
    sq_start  = 1'b0;
    div_start = 1'b0;
    div_num   = ax_mag[bss_pkg::DIV_NW-1:0];
    div_den   = len_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = mode_i ? S_SQ : S_START;
      end
      S_START: begin
        if (slot_free) state_d = S_IDLE;
      end
      S_SQ:     state_d = S_ROOT;
      S_ROOT: begin
        sq_start = 1'b1;
        state_d  = S_ROOT_W;
      end
      S_ROOT_W: begin
        if (sq_done) begin
          if (phase_q) begin
            state_d = S_MUL;
          end else if (trav_new <= {10'b0, sp_w}) begin
            state_d = S_IDLE;
          end else begin
            div_start = 1'b1;
            div_num   = {1'b0, trav_new};
            div_den   = {6'b0, sp_w};
            state_d   = S_STEPS;
          end
        end
      end
      S_STEPS: begin
        if (div_done) state_d = S_SQ;
      end
      S_MUL:    state_d = S_DIVX;
      S_DIVX: begin
        if (len_q == '0) begin
          state_d = S_STEP;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIVX_W;
        end
      end
      S_DIVX_W: begin
        if (div_done) state_d = S_DIVY;
      end
      S_DIVY: begin
        div_start = 1'b1;
        div_num   = ay_mag[bss_pkg::DIV_NW-1:0];
        state_d   = S_DIVY_W;
      end
      S_DIVY_W: begin
        if (div_done) state_d = S_STEP;
      end
      S_STEP:   state_d = S_EMIT;
      S_EMIT: begin
        if (slot_free) state_d = last_w ? S_IDLE : S_STEP;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      spacing_q  <= bss_pkg::SPACE_RST;
      anchor_x_q <= '0;
      anchor_y_q <= '0;
      prev_x_q   <= '0;
      prev_y_q   <= '0;
      trav_q     <= '0;
      phase_q    <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) spacing_q <= cfg_wdata_i;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          phase_q <= 1'b0;
          if (in_valid_i && !mode_i) begin
            anchor_x_q <= pen_x_w;
            anchor_y_q <= pen_y_w;
            prev_x_q   <= pen_x_w;
            prev_y_q   <= pen_y_w;
            trav_q     <= '0;
          end
        end
        S_ROOT_W: begin
          if (sq_done && !phase_q) begin
            trav_q   <= trav_new;
            prev_x_q <= px_q;
            prev_y_q <= py_q;
          end
        end
        S_STEPS: begin
          if (div_done) phase_q <= 1'b1;
        end
        S_EMIT: begin
          if (slot_free && last_w) begin
            anchor_x_q <= dab_x_w;
            anchor_y_q <= dab_y_w;
            trav_q     <= trav_q - {3'b0, used_q};
          end
        end
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      px_q <= pen_x_w;
      py_q <= pen_y_w;
    end
    if (state_q == S_SQ) begin
      sqx_q <= sqx_full[21:0];
      sqy_q <= sqy_full[21:0];
    end
    if (state_q == S_ROOT_W && sq_done) len_q <= sq_root;
    if (state_q == S_STEPS && div_done) begin
      // cap the dab count
      steps_q <= (div_quo > bss_pkg::DIV_NW'(bss_pkg::MAX_STAMPS))
                 ? bss_pkg::STEPS_W'(bss_pkg::MAX_STAMPS) : div_quo[bss_pkg::STEPS_W-1:0];
    end
    if (state_q == S_MUL) begin
      ax_q   <= ax_full;
      ay_q   <= ay_full;
      used_q <= 17'(steps_q * sp_w);
      qx_q   <= '0;
      qy_q   <= '0;
      rx_q   <= '0;
      ry_q   <= '0;
      k_q    <= '0;
      // pen on the anchor: every dab stays at the anchor
      qx_step_q <= '0;
      qy_step_q <= '0;
      rx_step_q <= '0;
      ry_step_q <= '0;
    end
    if (state_q == S_DIVX_W && div_done) begin
      qx_step_q <= q_step_w;
      rx_step_q <= r_step_w;
    end
    if (state_q == S_DIVY_W && div_done) begin
      qy_step_q <= q_step_w;
      ry_step_q <= r_step_w;
    end
    if (state_q == S_STEP) begin
      k_q <= k_q + bss_pkg::STEPS_W'(1);
      if (len_q != '0 && rx_sum >= {1'b0, len_q}) begin
        rx_q <= 16'(rx_sum - {1'b0, len_q});
        qx_q <= qx_q + qx_step_q + 16'sd1;
      end else begin
        rx_q <= rx_sum[15:0];
        qx_q <= qx_q + qx_step_q;
      end
      if (len_q != '0 && ry_sum >= {1'b0, len_q}) begin
        ry_q <= 16'(ry_sum - {1'b0, len_q});
        qy_q <= qy_q + qy_step_q + 16'sd1;
      end else begin
        ry_q <= ry_sum[15:0];
        qy_q <= qy_q + qy_step_q;
      end
    end
    if (out_load) begin
      dab_x_q <= load_x;
      dab_y_q <= load_y;
      last_q  <= last_w;
    end
  end

  assign out_valid_o = out_vld_q;
  assign dab_x_o     = dab_x_q;
  assign dab_y_o     = dab_y_q;
  assign last_dab_o  = last_q;

  `BSS_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, state_q != S_IDLE, "event not taken")
  `BSS_ASSERT_NEXT(a_last_idle, out_load && last_w, state_q == S_IDLE, "last dab without idle")
  `BSS_ASSERT_NOW(a_steps_range, state_q == S_EMIT, (steps_q != '0) && (steps_q <= bss_pkg::STEPS_W'(bss_pkg::MAX_STAMPS)), "dab count out of range")
endmodule

@@ bench/brush_stroke_stamp_spacer_unit_tb.sv @@
// testbench for brush_stroke_stamp_spacer_unit: pen events in, dab beats out, checked
// against a cycle-free predictor of the dab spacing; depends on bss_pkg and the rtl
`timescale 1ns / 1ps

module brush_stroke_stamp_spacer_unit_tb;

  typedef logic [bss_pkg::COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } dab_t;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_MOVE  = 1'b1;
  localparam int   QUIET_LIMIT = 20000;
  localparam int   SETTLE_CYCLES = 200;
  localparam longint TRAVEL_SAT = 1048575;

  // scoreboard: tracks stroke state and holds the dabs still owed by the block
  class dab_scoreboard;
    longint anchor_x, anchor_y, prev_x, prev_y, travelled;
    int     spacing;
    dab_t   owed[$];
    int     errors;

    function void clear();
      anchor_x = 0; anchor_y = 0; prev_x = 0; prev_y = 0;
      travelled = 0; spacing = 32; errors = 0;
      owed.delete();
    endfunction

    function longint unsigned int_root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // length in 1/16 pixel, truncated
    function longint length_q4(longint ax, longint ay, longint bx, longint by);
      longint dx, dy;
      dx = ax - bx;
      dy = ay - by;
      return longint'(int_root(longint'(dx * dx + dy * dy) * 256));
    endfunction

    function longint div_floor(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
    endfunction

    function longint clamp(longint v);
      if (v < 0) return 0;
      if (v > bss_pkg::CANVAS_SIZE - 1) return bss_pkg::CANVAS_SIZE - 1;
      return v;
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // append one expected dab
    function void owe(longint x, longint y, logic last);
      dab_t d;
      d.x  = coord_t'(x);
      d.y  = coord_t'(y);
      d.last = last;
      owed.insert(owed.size(), d);
    endfunction

    // an accepted pen event; queues every dab it should cause
    function void note_event(logic mode, coord_t px_in, coord_t py_in);
      longint px, py, sp, steps, len, dx, dy, nx, ny;
      px = clamp(px_in);
      py = clamp(py_in);
      sp = (spacing == 0) ? 1 : spacing;
      if (mode == MODE_START) begin
        travelled = 0;
        anchor_x = px; anchor_y = py; prev_x = px; prev_y = py;
        owe(px, py, 1'b1);
        return;
      end
      travelled += length_q4(prev_x, prev_y, px, py);
      if (travelled > TRAVEL_SAT) travelled = TRAVEL_SAT;
      prev_x = px;
      prev_y = py;
      if (travelled <= sp) return;
      steps = travelled / sp;
      if (steps > bss_pkg::MAX_STAMPS) steps = bss_pkg::MAX_STAMPS;
      len = length_q4(px, py, anchor_x, anchor_y);
      dx = px - anchor_x;
      dy = py - anchor_y;
      nx = anchor_x;
      ny = anchor_y;
      for (longint k = 1; k <= steps; k++) begin
        // pen sitting on the anchor: dabs pile up on the anchor
        if (len != 0) begin
          nx = clamp(anchor_x + div_floor(k * sp * dx, len));
          ny = clamp(anchor_y + div_floor(k * sp * dy, len));
        end
        owe(nx, ny, logic'(k == steps));
      end
      anchor_x = nx;
      anchor_y = ny;
      travelled -= steps * sp;
    endfunction

    task check_dab(coord_t x, coord_t y, logic last);
      dab_t e;
      if (owed.size() == 0) begin
        report($sformatf("unexpected dab x=%0d y=%0d last=%0d", x, y, last));
        return;
      end
      e = owed.pop_front();
      if (x !== e.x) report($sformatf("dab_x got %0d want %0d", x, e.x));
      if (y !== e.y) report($sformatf("dab_y got %0d want %0d", y, e.y));
      if (last !== e.last) report($sformatf("last_dab got %0d want %0d", last, e.last));
    endtask
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [bss_pkg::SPACE_W-1:0]  cfg_wdata_i;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic                         mode_i;
  coord_t                       pen_x_i;
  coord_t                       pen_y_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  coord_t                       dab_x_o;
  coord_t                       dab_y_o;
  logic                         last_dab_o;

  dab_scoreboard sb;
  int  tx_idle_pct;
  int  rx_stall_pct;
  bit  rx_hold;
  int  quiet_cycles;
  int  events_sent;
  longint cur_x, cur_y;

  brush_stroke_stamp_spacer_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .pen_x_i     (pen_x_i),
    .pen_y_i     (pen_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dab_x_o     (dab_x_o),
    .dab_y_o     (dab_y_o),
    .last_dab_o  (last_dab_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: stall decided at the falling edge, dab beats taken at the rising edge
  always @(negedge clk_i) begin
    out_stall_i <= rx_hold || ($urandom_range(0, 99) < rx_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_dab(dab_x_o, dab_y_o, last_dab_o);
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one pen event, with random idle cycles first; valid stays high after the beat
  task send_event(logic mode, longint x, longint y);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    pen_x_i    <= coord_t'(x);
    pen_y_i    <= coord_t'(y);
    do @(posedge clk_i); while (in_stall_o);
    sb.note_event(mode, coord_t'(x), coord_t'(y));
    events_sent++;
  endtask

  task drop_valid();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // sender pause: every owed dab out, then room for a silent move to finish
  task drain();
    drop_valid();
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task write_spacing(int unsigned value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= bss_pkg::SPACE_W'(value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.spacing = value;
  endtask

  function longint wander(longint v, int reach);
    longint n;
    n = v + $signed($urandom_range(0, 2 * reach)) - reach;
    if (n < 0) n = 0;
    if (n > bss_pkg::CANVAS_SIZE - 1) n = bss_pkg::CANVAS_SIZE - 1;
    return n;
  endfunction

  // one stroke: usually a start, then a run of moves; now and then a jump or a stray event
  task random_stroke();
    int n;
    int roll;
    if ($urandom_range(0, 9) != 0) begin
      cur_x = $urandom_range(0, bss_pkg::CANVAS_SIZE - 1);
      cur_y = $urandom_range(0, bss_pkg::CANVAS_SIZE - 1);
      send_event(MODE_START, cur_x, cur_y);
    end
    n = $urandom_range(2, 10);
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        // noise: any mode, anywhere
        cur_x = $urandom_range(0, bss_pkg::CANVAS_SIZE - 1);
        cur_y = $urandom_range(0, bss_pkg::CANVAS_SIZE - 1);
        send_event(logic'($urandom_range(0, 1)), cur_x, cur_y);
      end else if (roll < 15) begin
        cur_x = wander(cur_x, 400);
        cur_y = wander(cur_y, 400);
        send_event(MODE_MOVE, cur_x, cur_y);
      end else begin
        cur_x = wander(cur_x, 24);
        cur_y = wander(cur_y, 24);
        send_event(MODE_MOVE, cur_x, cur_y);
      end
    end
  endtask

  initial begin
    int spacings[4];
    sb = new();
    sb.clear();
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    mode_i       = MODE_START;
    pen_x_i      = '0;
    pen_y_i      = '0;
    rx_hold      = 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    events_sent  = 0;
    cur_x = 0;
    cur_y = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // move before any start, from the reset state
    send_event(MODE_MOVE, 3, 0);
    // zero move, then exactly one spacing (no dab), then just past it
    send_event(MODE_START, 0, 0);
    send_event(MODE_MOVE, 0, 0);
    send_event(MODE_MOVE, 2, 0);
    send_event(MODE_MOVE, 3, 0);
    // corners
    send_event(MODE_START, bss_pkg::CANVAS_SIZE - 1, bss_pkg::CANVAS_SIZE - 1);
    send_event(MODE_MOVE, bss_pkg::CANVAS_SIZE - 1, bss_pkg::CANVAS_SIZE - 5);
    send_event(MODE_MOVE, bss_pkg::CANVAS_SIZE - 6, bss_pkg::CANVAS_SIZE - 1);
    // pen returns onto the anchor with dabs due
    send_event(MODE_START, 500, 500);
    send_event(MODE_MOVE, 502, 500);
    send_event(MODE_MOVE, 500, 500);
    // diagonal toward the origin, negative direction on both axes
    send_event(MODE_MOVE, 480, 470);
    drain();

    // finest spacing: capped dab count, leftover carries
    write_spacing(1);
    send_event(MODE_START, 0, 0);
    send_event(MODE_MOVE, bss_pkg::CANVAS_SIZE - 1, bss_pkg::CANVAS_SIZE - 1);
    send_event(MODE_MOVE, 0, bss_pkg::CANVAS_SIZE - 1);
    drain();
    // spacing of zero acts as one
    write_spacing(0);
    send_event(MODE_START, 1024, 1024);
    send_event(MODE_MOVE, 1030, 1020);
    drain();
    // widest spacing
    write_spacing(1023);
    send_event(MODE_START, 0, 1000);
    send_event(MODE_MOVE, 2047, 1000);
    send_event(MODE_MOVE, 0, 1000);
    drain();

    // long scribble at spacing one: travelled length saturates
    write_spacing(1);
    send_event(MODE_START, 0, 0);
    for (int i = 0; i < 26; i++) begin
      if (i % 2 == 0) begin
        send_event(MODE_MOVE, bss_pkg::CANVAS_SIZE - 1, bss_pkg::CANVAS_SIZE - 1);
      end else begin
        send_event(MODE_MOVE, 0, 0);
      end
    end
    drain();

    spacings[0] = 32;
    spacings[1] = 800;
    spacings[2] = $urandom_range(1, 200);
    spacings[3] = 16;
    for (int ph = 0; ph < 4; ph++) begin
      write_spacing(spacings[ph]);
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 68; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 68; end
        default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
      endcase
      if (ph == 0) begin
        // long receiver hold-off while events keep coming
        fork
          begin
            rx_hold = 1'b1;
            repeat (600) @(posedge clk_i);
            rx_hold = 1'b0;
          end
        join_none
      end
      while (events_sent < 45 + 55 * (ph + 1)) random_stroke();
      drain();
    end

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    write_spacing(32);
    send_event(MODE_START, 10, 10);
    send_event(MODE_MOVE, 40, 50);
    drain();

    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
